/* hw/rtl/n2r_pkg.sv */
// ----------------------------------------------------------------------------
// n2r_pkg
// Shared types, register codes and colour-space constants for the NV21 to
// RGB888 converter.
// ----------------------------------------------------------------------------
package n2r_pkg;

    // Configuration port layout and register codes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned DIM_REG_W   = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

    // Fixed-point conversion coefficients (scaled by 1024)
    localparam logic [7:0]         LUMA_OFFSET   = 8'd16;
    localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;
    localparam logic [18:0]        COEF_Y        = 19'd1192;
    localparam logic signed [20:0] COEF_RV       = 21'sd1634;
    localparam logic signed [20:0] COEF_GV       = 21'sd833;
    localparam logic signed [20:0] COEF_GU       = 21'sd400;
    localparam logic signed [20:0] COEF_BU       = 21'sd2066;
    localparam logic signed [20:0] CLAMP_TOP     = 21'sh03FFFF;

    // Frame byte phase
    typedef enum logic {
        PH_LUMA,
        PH_CHROMA
    } phase_t;

    // Input word
    typedef struct packed {
        logic [7:0] sample_byte;
    } sample_t;

    // Output word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] pixel_row;
        logic [9:0] pixel_column;
        logic       run_last;
        logic       frame_last;
    } pixel_t;

    // Configuration write word
    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [DIM_REG_W-1:0]   data;
    } cfg_word_t;

    // One pixel's operands handed to the colour pipeline
    typedef struct packed {
        logic       valid;
        logic [7:0] luma;
        logic [7:0] u;
        logic [7:0] v;
        logic [9:0] row;
        logic [9:0] column;
        logic       run_last;
        logic       frame_last;
    } calc_in_t;

    // Clamp to 0..0x3FFFF and keep bits 17..10
    function automatic logic [7:0] clamp_channel(input logic signed [20:0] x);
        logic [7:0] res;
        if (x < 0)
        begin
            res = 8'd0;
        end
        else if (x > CLAMP_TOP)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = x[17:10];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/n2r_stream_if.sv */
// ----------------------------------------------------------------------------
// n2r_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface n2r_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/n2r_pixel_calc.sv */
// ----------------------------------------------------------------------------
// n2r_pixel_calc
// Two-stage colour pipeline: constant products, then sums, clamp and the
// output register. Both stages move together on the advance strobe.
// ----------------------------------------------------------------------------
module n2r_pixel_calc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  n2r_pkg::calc_in_t calc_in,
    output logic              out_valid,
    output n2r_pkg::pixel_t   pixel
);

    // Stage A registers
    logic                  a_valid_reg;
    logic [18:0]           a_yt_reg;
    logic signed [20:0]    a_rv_reg;
    logic signed [20:0]    a_gv_reg;
    logic signed [20:0]    a_gu_reg;
    logic signed [20:0]    a_bu_reg;
    logic [9:0]            a_row_reg;
    logic [9:0]            a_col_reg;
    logic                  a_run_last_reg;
    logic                  a_frame_last_reg;

    // Output register
    logic                  o_valid_reg;
    n2r_pkg::pixel_t       o_pixel_reg;

    logic [7:0]            y_off;
    logic signed [8:0]     u_s;
    logic signed [8:0]     v_s;
    logic signed [20:0]    u_ext;
    logic signed [20:0]    v_ext;
    logic signed [20:0]    yt_ext;
    logic signed [20:0]    r_sum;
    logic signed [20:0]    g_sum;
    logic signed [20:0]    b_sum;

    // Remove offsets
    always_comb
    begin
        y_off  = (calc_in.luma < n2r_pkg::LUMA_OFFSET) ? 8'd0
                                                       : calc_in.luma - n2r_pkg::LUMA_OFFSET;
        u_s    = $signed({1'b0, calc_in.u}) - n2r_pkg::CHROMA_OFFSET;
        v_s    = $signed({1'b0, calc_in.v}) - n2r_pkg::CHROMA_OFFSET;
        u_ext  = 21'(u_s);
        v_ext  = 21'(v_s);
    end

    // Valid bits: cleared on reset, moved on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= calc_in.valid;
            o_valid_reg <= a_valid_reg;
        end
    end

    // Stage A: constant products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_yt_reg         <= 19'(y_off) * n2r_pkg::COEF_Y;
            a_rv_reg         <= v_ext * n2r_pkg::COEF_RV;
            a_gv_reg         <= v_ext * n2r_pkg::COEF_GV;
            a_gu_reg         <= u_ext * n2r_pkg::COEF_GU;
            a_bu_reg         <= u_ext * n2r_pkg::COEF_BU;
            a_row_reg        <= calc_in.row;
            a_col_reg        <= calc_in.column;
            a_run_last_reg   <= calc_in.run_last;
            a_frame_last_reg <= calc_in.frame_last;
        end
    end

    // Stage B: sums and clamp
    always_comb
    begin
        yt_ext = $signed({2'b00, a_yt_reg});
        r_sum  = yt_ext + a_rv_reg;
        g_sum  = yt_ext - a_gv_reg - a_gu_reg;
        b_sum  = yt_ext + a_bu_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_pixel_reg.red          <= n2r_pkg::clamp_channel(r_sum);
            o_pixel_reg.green        <= n2r_pkg::clamp_channel(g_sum);
            o_pixel_reg.blue         <= n2r_pkg::clamp_channel(b_sum);
            o_pixel_reg.pixel_row    <= a_row_reg;
            o_pixel_reg.pixel_column <= a_col_reg;
            o_pixel_reg.run_last     <= a_run_last_reg;
            o_pixel_reg.frame_last   <= a_frame_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign pixel     = o_pixel_reg;

endmodule

/* hw/rtl/nv21_to_rgb888_converter.sv */
// ----------------------------------------------------------------------------
// nv21_to_rgb888_converter
// NV21 byte stream in, one RGB888 pixel word with coordinates out. The luma
// plane is kept in an on-chip RAM; each V,U pair reads its 2x2 luma block.
// ----------------------------------------------------------------------------
//
//  channel    | dir | word          | meaning
//  -----------+-----+---------------+------------------------------------------
//  sample_in  | in  | sample_t      | frame bytes: luma plane, then V,U pairs
//  pixel_out  | out | pixel_t       | colour, row, column, block/frame end
//  cfg        | in  | cfg_word_t    | frame_width (0), frame_height (1)
//
//  Luma and V bytes are taken one per cycle. A U byte starts four reads on the
//  single read port of the luma RAM, one per cycle while the output is not
//  stalled; the next U byte is taken as the last of them issues. The first
//  luma byte of the next frame waits until the last block's reads are issued.
//  Reset clears control state only; the luma RAM needs no clearing pass. A
//  stalled output freezes the read and colour pipeline; V bytes are still
//  taken meanwhile, and luma bytes when no block's reads are pending.
//
module nv21_to_rgb888_converter #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    n2r_stream_if.sink   sample_in,
    n2r_stream_if.source pixel_out,
    n2r_stream_if.sink   cfg
);

    localparam int unsigned WDW   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HDW   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CXW   = $clog2(MAX_WIDTH);
    localparam int unsigned RYW   = $clog2(MAX_HEIGHT);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    // Configuration registers
    logic [n2r_pkg::DIM_REG_W-1:0] width_reg;
    logic [n2r_pkg::DIM_REG_W-1:0] height_reg;

    // Frame position state
    n2r_pkg::phase_t phase_reg, phase_next;
    logic            parity_reg, parity_next;
    logic [AW-1:0]   waddr_reg, waddr_next;
    logic [CXW-1:0]  lcol_reg, lcol_next;
    logic [RYW-1:0]  lrow_reg, lrow_next;
    logic [CXW-1:0]  c0_reg, c0_next;
    logic [RYW-1:0]  r0_reg, r0_next;
    logic [AW-1:0]   tl_reg, tl_next;
    logic [7:0]      held_v_reg, held_v_next;

    // Block read job
    logic            job_busy_reg, job_busy_next;
    logic [1:0]      job_k_reg, job_k_next;
    logic [AW-1:0]   job_tl_reg;
    logic [CXW-1:0]  job_c0_reg;
    logic [RYW-1:0]  job_r0_reg;
    logic [7:0]      job_u_reg;
    logic [7:0]      job_v_reg;
    logic            job_last_reg;

    // Read stage
    logic            s1_valid_reg;
    logic [7:0]      rd_data_reg;
    logic [7:0]      s1_u_reg;
    logic [7:0]      s1_v_reg;
    logic [9:0]      s1_row_reg;
    logic [9:0]      s1_col_reg;
    logic            s1_run_last_reg;
    logic            s1_frame_last_reg;

    logic [7:0]      luma_mem [DEPTH];

    logic [31:0]     w_tmp;
    logic [31:0]     h_tmp;
    logic [WDW-1:0]  frame_w;
    logic [HDW-1:0]  frame_h;
    logic [WDW-1:0]  w_m1;
    logic [WDW-1:0]  w_m2;
    logic [HDW-1:0]  h_m1;
    logic [HDW-1:0]  h_m2;

    logic            advance;
    logic            in_fire;
    logic            cfg_fire;
    logic            in_ready;
    logic            luma_we;
    logic            job_load;
    logic            job_issue;
    logic            row_end;
    logic            frame_end;
    logic [7:0]      in_byte;
    logic [AW-1:0]   rd_addr;
    logic [RYW-1:0]  issue_row;
    logic [CXW-1:0]  issue_col;

    n2r_pkg::calc_in_t calc_in;
    n2r_pkg::pixel_t   pix;
    logic              pix_valid;

    // Fit the frame dimensions: clear the low bit, floor at 2, cap at maximum
    always_comb
    begin
        w_tmp = 32'(width_reg & 11'h7FE);
        if (w_tmp < 32'd2)
        begin
            w_tmp = 32'd2;
        end
        if (w_tmp > 32'(MAX_WIDTH))
        begin
            w_tmp = 32'(MAX_WIDTH) & ~32'd1;
        end
        h_tmp = 32'(height_reg & 11'h7FE);
        if (h_tmp < 32'd2)
        begin
            h_tmp = 32'd2;
        end
        if (h_tmp > 32'(MAX_HEIGHT))
        begin
            h_tmp = 32'(MAX_HEIGHT) & ~32'd1;
        end
        frame_w = WDW'(w_tmp);
        frame_h = HDW'(h_tmp);
        w_m1    = frame_w - WDW'(1);
        w_m2    = frame_w - WDW'(2);
        h_m1    = frame_h - HDW'(1);
        h_m2    = frame_h - HDW'(2);
    end

    // Handshakes
    assign advance  = !pix_valid || pixel_out.ready;
    assign in_byte  = sample_in.payload.sample_byte;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (phase_reg == n2r_pkg::PH_LUMA)
        begin
            in_ready = !job_busy_reg;
        end
        else if (!parity_reg)
        begin
            in_ready = 1'b1;
        end
        else
        begin
            in_ready = !job_busy_reg || (job_k_reg == 2'd3 && advance);
        end
    end

    assign sample_in.ready = in_ready;
    assign in_fire         = sample_in.valid && in_ready;
    assign luma_we         = in_fire && (phase_reg == n2r_pkg::PH_LUMA);
    assign job_load        = in_fire && (phase_reg == n2r_pkg::PH_CHROMA) && parity_reg;
    assign job_issue       = job_busy_reg && advance;
    assign row_end         = (WDW'(c0_reg) == w_m2);
    assign frame_end       = row_end && (HDW'(r0_reg) == h_m2);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= n2r_pkg::FRAME_WIDTH_RESET;
            height_reg <= n2r_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg.payload.index)
                n2r_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg.payload.data;
                n2r_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg.payload.data;
                default: ;
            endcase
        end
    end

    // Advance the frame position on each accepted byte; a dimension write restarts the frame
    always_comb
    begin
        phase_next  = phase_reg;
        parity_next = parity_reg;
        waddr_next  = waddr_reg;
        lcol_next   = lcol_reg;
        lrow_next   = lrow_reg;
        c0_next     = c0_reg;
        r0_next     = r0_reg;
        tl_next     = tl_reg;
        held_v_next = held_v_reg;

        if (cfg_fire && (cfg.payload.index == n2r_pkg::CFG_FRAME_WIDTH ||
                         cfg.payload.index == n2r_pkg::CFG_FRAME_HEIGHT))
        begin
            phase_next  = n2r_pkg::PH_LUMA;
            parity_next = 1'b0;
            waddr_next  = '0;
            lcol_next   = '0;
            lrow_next   = '0;
            c0_next     = '0;
            r0_next     = '0;
            tl_next     = '0;
            held_v_next = 8'd0;
        end
        else if (in_fire)
        begin
            case (phase_reg)
                n2r_pkg::PH_LUMA:
                begin
                    waddr_next = waddr_reg + AW'(1);
                    if (WDW'(lcol_reg) == w_m1)
                    begin
                        lcol_next = '0;
                        lrow_next = lrow_reg + RYW'(1);
                        if (HDW'(lrow_reg) == h_m1)
                        begin
                            phase_next  = n2r_pkg::PH_CHROMA;
                            parity_next = 1'b0;
                            waddr_next  = '0;
                            lrow_next   = '0;
                            c0_next     = '0;
                            r0_next     = '0;
                            tl_next     = '0;
                        end
                    end
                    else
                    begin
                        lcol_next = lcol_reg + CXW'(1);
                    end
                end
                n2r_pkg::PH_CHROMA:
                begin
                    if (!parity_reg)
                    begin
                        held_v_next = in_byte;
                        parity_next = 1'b1;
                    end
                    else
                    begin
                        parity_next = 1'b0;
                        if (frame_end)
                        begin
                            phase_next = n2r_pkg::PH_LUMA;
                            c0_next    = '0;
                            r0_next    = '0;
                            tl_next    = '0;
                        end
                        else if (row_end)
                        begin
                            c0_next = '0;
                            r0_next = r0_reg + RYW'(2);
                            tl_next = tl_reg + AW'(2) + AW'(frame_w);
                        end
                        else
                        begin
                            c0_next = c0_reg + CXW'(2);
                            tl_next = tl_reg + AW'(2);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= n2r_pkg::PH_LUMA;
            parity_reg <= 1'b0;
            waddr_reg  <= '0;
            lcol_reg   <= '0;
            lrow_reg   <= '0;
            c0_reg     <= '0;
            r0_reg     <= '0;
            tl_reg     <= '0;
            held_v_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            parity_reg <= parity_next;
            waddr_reg  <= waddr_next;
            lcol_reg   <= lcol_next;
            lrow_reg   <= lrow_next;
            c0_reg     <= c0_next;
            r0_reg     <= r0_next;
            tl_reg     <= tl_next;
            held_v_reg <= held_v_next;
        end
    end

    // Job sequencer: step through the four pixels of a block
    always_comb
    begin
        job_busy_next = job_busy_reg;
        job_k_next    = job_k_reg;
        if (job_issue)
        begin
            job_k_next = job_k_reg + 2'd1;
            if (job_k_reg == 2'd3)
            begin
                job_busy_next = 1'b0;
            end
        end
        if (job_load)
        begin
            job_busy_next = 1'b1;
            job_k_next    = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_busy_reg <= 1'b0;
            job_k_reg    <= 2'd0;
        end
        else
        begin
            job_busy_reg <= job_busy_next;
            job_k_reg    <= job_k_next;
        end
    end

    // Latch the block on its U byte
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_tl_reg   <= tl_reg;
            job_c0_reg   <= c0_reg;
            job_r0_reg   <= r0_reg;
            job_u_reg    <= in_byte;
            job_v_reg    <= held_v_reg;
            job_last_reg <= frame_end;
        end
    end

    // Read address and coordinates of the pixel being issued
    always_comb
    begin
        rd_addr   = job_tl_reg + (job_k_reg[1] ? AW'(frame_w) : AW'(0))
                    + AW'(job_k_reg[0]);
        issue_row = job_r0_reg + RYW'(job_k_reg[1]);
        issue_col = job_c0_reg + CXW'(job_k_reg[0]);
    end

    // Luma RAM: write port for the luma plane, registered read port
    always_ff @(posedge clk)
    begin
        if (luma_we)
        begin
            luma_mem[waddr_reg] <= in_byte;
        end
        if (advance)
        begin
            rd_data_reg <= luma_mem[rd_addr];
        end
    end

    // Read stage side information
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= job_busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_u_reg          <= job_u_reg;
            s1_v_reg          <= job_v_reg;
            s1_row_reg        <= 10'(issue_row);
            s1_col_reg        <= 10'(issue_col);
            s1_run_last_reg   <= (job_k_reg == 2'd3);
            s1_frame_last_reg <= job_last_reg && (job_k_reg == 2'd3);
        end
    end

    always_comb
    begin
        calc_in.valid      = s1_valid_reg;
        calc_in.luma       = rd_data_reg;
        calc_in.u          = s1_u_reg;
        calc_in.v          = s1_v_reg;
        calc_in.row        = s1_row_reg;
        calc_in.column     = s1_col_reg;
        calc_in.run_last   = s1_run_last_reg;
        calc_in.frame_last = s1_frame_last_reg;
    end

    // Colour pipeline and output register
    n2r_pixel_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .calc_in   (calc_in),
        .out_valid (pix_valid),
        .pixel     (pix)
    );

    assign pixel_out.valid   = pix_valid;
    assign pixel_out.payload = pix;

endmodule

/* hw/rtl/n2r_checker.sv */
// ----------------------------------------------------------------------------
// n2r_checker
// Port-level checks on the pixel output of the converter, bound to the top.
// ----------------------------------------------------------------------------
module n2r_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input n2r_pkg::pixel_t pixel
);

    // Hold a stalled word
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel))
        else $error("pixel word changed while stalled");

    // Frame end falls on a block end
    a_frame_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel.frame_last |-> pixel.run_last)
        else $error("frame_last without run_last");

    // Block end is the bottom-right pixel
    a_block_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel.run_last |-> pixel.pixel_row[0] && pixel.pixel_column[0])
        else $error("run_last away from bottom-right pixel");

    // Bottom-right pixel always ends its block
    a_block_end_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel.pixel_row[0] && pixel.pixel_column[0] |-> pixel.run_last)
        else $error("bottom-right pixel without run_last");

endmodule

bind nv21_to_rgb888_converter n2r_checker u_n2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .pixel     (pixel_out.payload)
);

/* test/nv21_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv21_pixel_checker
// Watches the sample, pixel and register channels of the converter. It keeps
// its own copy of the frame geometry, the luma plane and the held V byte,
// works out the four pixels due on every U byte and compares each pixel word
// taken from the block, field by field, against the oldest one still owed.
// ----------------------------------------------------------------------------
module nv21_pixel_checker
    import n2r_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    input  logic      sample_ready,
    input  sample_t   sample_word,
    input  logic      pixel_valid,
    input  logic      pixel_ready,
    input  pixel_t    pixel_word,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_word_t cfg_word,
    output int        pixels_left,
    output int        fail_count
);

    localparam int unsigned LUMA_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int          CHANNEL_TOP = 'h3FFFF;
    localparam int          Y_GAIN      = 1192;
    localparam int          RV_GAIN     = 1634;
    localparam int          GV_GAIN     = 833;
    localparam int          GU_GAIN     = 400;
    localparam int          BU_GAIN     = 2066;

    bit   [7:0]  luma_copy [0:LUMA_DEPTH-1];
    logic [20:0] byte_pos;
    logic [7:0]  held_v;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    pixel_t      owed_pixels [$];
    int          pixels_seen;

    // Even dimension, at least 2, saturated to the maximum
    function automatic int unsigned fit_dim(input logic [10:0] reg_value,
                                            input int unsigned maxv);
        int unsigned d;
        d = {reg_value[10:1], 1'b0};
        if (d < 2)
        begin
            d = 2;
        end
        if (d > maxv)
        begin
            d = maxv & ~32'd1;
        end
        return d;
    endfunction

    // Clamp to the 18-bit range and keep the top eight bits
    function automatic logic [7:0] to_channel(input int x);
        logic [7:0] res;
        if (x < 0)
        begin
            res = 8'd0;
        end
        else if (x > CHANNEL_TOP)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = x[17:10];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int exp_v);
        fail_count++;
        $display("pixel %0d: %s got %0d expected %0d", pixels_seen, what, got_v, exp_v);
    endtask

    // Store luma, hold V, and on U queue the 2x2 block it covers
    task automatic predict_sample(input logic [7:0] b);
        int unsigned w, h, luma_len, total, pos, c, pair_no, r0, c0, row, col, idx;
        int          u, v, y, yt, k;
        logic        frame_end;
        logic [7:0]  luma;
        pixel_t      px;
        w        = fit_dim(width_reg, MAX_WIDTH);
        h        = fit_dim(height_reg, MAX_HEIGHT);
        luma_len = w * h;
        total    = luma_len + luma_len / 2;
        pos      = byte_pos;
        if (pos >= total)
        begin
            pos = 0;
        end
        if (pos < luma_len)
        begin
            if (pos < LUMA_DEPTH)
            begin
                luma_copy[pos] = b;
            end
            byte_pos = 21'(pos + 1);
        end
        else
        begin
            c        = pos - luma_len;
            byte_pos = (pos + 1 >= total) ? 21'd0 : 21'(pos + 1);
            if (c[0] == 1'b0)
            begin
                held_v = b;
            end
            else
            begin
                pair_no   = c >> 1;
                r0        = (pair_no / (w / 2)) * 2;
                c0        = (pair_no % (w / 2)) * 2;
                v         = int'(held_v) - 128;
                u         = int'(b) - 128;
                frame_end = (pos + 1 >= total);
                for (k = 0; k < 4; k++)
                begin
                    row  = r0 + k / 2;
                    col  = c0 + k % 2;
                    idx  = row * w + col;
                    luma = (idx < LUMA_DEPTH) ? luma_copy[idx] : 8'd0;
                    y    = int'(luma) - 16;
                    if (y < 0)
                    begin
                        y = 0;
                    end
                    yt              = Y_GAIN * y;
                    px.red          = to_channel(yt + RV_GAIN * v);
                    px.green        = to_channel(yt - GV_GAIN * v - GU_GAIN * u);
                    px.blue         = to_channel(yt + BU_GAIN * u);
                    px.pixel_row    = row[9:0];
                    px.pixel_column = col[9:0];
                    px.run_last     = (k == 3);
                    px.frame_last   = frame_end && (k == 3);
                    owed_pixels.push_back(px);
                end
            end
        end
    endtask

    // Compare one pixel word against the oldest owed one
    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (owed_pixels.size() == 0)
        begin
            report_mismatch("pixel word with none owed, row", got.pixel_row, 0);
        end
        else
        begin
            want = owed_pixels.pop_front();
            if (got.red != want.red)
                report_mismatch("red", got.red, want.red);
            if (got.green != want.green)
                report_mismatch("green", got.green, want.green);
            if (got.blue != want.blue)
                report_mismatch("blue", got.blue, want.blue);
            if (got.pixel_row != want.pixel_row)
                report_mismatch("pixel_row", got.pixel_row, want.pixel_row);
            if (got.pixel_column != want.pixel_column)
                report_mismatch("pixel_column", got.pixel_column, want.pixel_column);
            if (got.run_last != want.run_last)
                report_mismatch("run_last", got.run_last, want.run_last);
            if (got.frame_last != want.frame_last)
                report_mismatch("frame_last", got.frame_last, want.frame_last);
        end
        pixels_seen++;
    endtask

    // Track every accepted word on the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_pixels.delete();
            byte_pos    = '0;
            held_v      = '0;
            width_reg   = FRAME_WIDTH_RESET;
            height_reg  = FRAME_HEIGHT_RESET;
            pixels_seen = 0;
            pixels_left = 0;
            fail_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                // A write to either dimension restarts the frame; spare codes do nothing
                if (cfg_word.index == CFG_FRAME_WIDTH || cfg_word.index == CFG_FRAME_HEIGHT)
                begin
                    if (cfg_word.index == CFG_FRAME_WIDTH)
                    begin
                        width_reg = cfg_word.data;
                    end
                    else
                    begin
                        height_reg = cfg_word.data;
                    end
                    byte_pos = '0;
                    held_v   = '0;
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                check_pixel(pixel_word);
            end
            if (sample_valid && sample_ready)
            begin
                predict_sample(sample_word.sample_byte);
            end
            pixels_left = owed_pixels.size();
        end
    end

endmodule

/* test/nv21_to_rgb888_converter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv21_to_rgb888_converter_tb
// Feeds NV21 frames of many sizes into the converter, directed at first and
// then random, with bursty input, a stalling pixel sink and register writes
// between phases. A separate checker predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module nv21_to_rgb888_converter_tb;
    import n2r_pkg::*;

    localparam int unsigned MAX_W             = 1024;
    localparam int unsigned MAX_H             = 1024;
    localparam time         HALF_PERIOD       = 10ns;
    localparam int          RESET_CYCLES      = 8;
    localparam int          RANDOM_ITEMS      = 154;
    localparam int          FIRST_PHASE_BYTES = 48;
    localparam int          SETTLE_CYCLES     = 16;
    localparam int          END_CYCLES        = 32;
    localparam int          LONG_HOLD_CYCLES  = 300;
    localparam time         RUN_LIMIT         = 20ms;

    // Register codes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_pattern_t;

    logic clk;
    logic rst_n;
    int   pixels_left;
    int   fail_count;

    n2r_stream_if #(.payload_t(sample_t))   sample_if ();
    n2r_stream_if #(.payload_t(pixel_t))    pixel_if ();
    n2r_stream_if #(.payload_t(cfg_word_t)) cfg_if ();

    // Sender and receiver state
    int          burst_left;
    bit          bursty;
    int          holds_asked;
    int          holds_done;
    rx_pattern_t rx_mode;
    int          rx_span;
    int          rx_tick;

    // Stimulus bookkeeping
    int          phase_no;
    int          random_items;
    int          eff_w;
    int          eff_h;
    int          frame_len;
    int          n_bytes;
    int          pause_at;
    int          i;

    nv21_to_rgb888_converter #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_if),
        .pixel_out (pixel_if),
        .cfg       (cfg_if)
    );

    nv21_pixel_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_if.valid),
        .sample_ready (sample_if.ready),
        .sample_word  (sample_if.payload),
        .pixel_valid  (pixel_if.valid),
        .pixel_ready  (pixel_if.ready),
        .pixel_word   (pixel_if.payload),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_word     (cfg_if.payload),
        .pixels_left  (pixels_left),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    // Stop a run that hangs
    initial
    begin
        #RUN_LIMIT;
        $display("nv21_to_rgb888_converter_tb: FAIL");
        $finish;
    end

    // Frame byte, biased towards the interesting values
    function automatic logic [7:0] random_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = 8'd0;
            1:       b = 8'd255;
            2:       b = 8'd16;
            3:       b = 8'd128;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Even dimension, mostly small
    function automatic int random_dim();
        int d;
        if ($urandom_range(0, 5) == 0)
        begin
            d = 2 * $urandom_range(5, 8);
        end
        else
        begin
            d = 2 * $urandom_range(1, 4);
        end
        return d;
    endfunction

    // Register value giving a dimension; the low bit and values below 2 fold in
    function automatic logic [10:0] dim_register(input int eff);
        logic [10:0] r;
        if (eff == 2)
        begin
            r = 11'($urandom_range(0, 3));
        end
        else
        begin
            r = 11'(eff) | 11'($urandom_range(0, 1));
        end
        return r;
    endfunction

    // Offer one word and wait for it to be taken
    task automatic send_byte(input logic [7:0] value);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            if (bursty)
            begin
                gap = $urandom_range(1, 6);
                sample_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        sample_if.payload = value;
        sample_if.valid   = 1'b1;
        @(posedge clk);
        while (!sample_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic lower_input();
        @(negedge clk);
        sample_if.valid = 1'b0;
    endtask

    // Drop valid, let every owed pixel out, then let the block go quiet
    task automatic settle_idle();
        lower_input();
        while (pixels_left != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [DIM_REG_W-1:0] value);
        @(negedge clk);
        cfg_if.payload = '{index: idx, data: value};
        cfg_if.valid   = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Pixel sink: changing stall patterns, plus a long hold when asked
    initial
    begin
        pixel_if.ready = 1'b0;
        rx_tick        = 0;
        holds_done     = 0;
        @(posedge rst_n);
        forever
        begin
            rx_mode = rx_pattern_t'($urandom_range(0, 3));
            rx_span = $urandom_range(32, 200);
            repeat (rx_span)
            begin
                @(negedge clk);
                if (holds_done != holds_asked)
                begin
                    pixel_if.ready = 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(negedge clk);
                    holds_done = holds_asked;
                end
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:     pixel_if.ready = 1'b1;
                    RX_COIN:     pixel_if.ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: pixel_if.ready = (rx_tick % 7) >= 3;
                    default:     pixel_if.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n             = 1'b0;
        sample_if.valid   = 1'b0;
        sample_if.payload = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.payload    = '0;
        burst_left        = 0;
        bursty            = 1'b0;
        holds_asked       = 0;
        random_items      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        settle_idle();

        // Directed: 2x2 frames with extreme luma and chroma
        write_register(CFG_FRAME_WIDTH, 11'd2);
        write_register(CFG_FRAME_HEIGHT, 11'd2);
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(8'd16);
        send_byte(8'd17);
        send_byte(8'd0);
        send_byte(8'd255);
        // Next frame follows straight after the wrap
        send_byte(8'd255);
        send_byte(8'd255);
        send_byte(8'd255);
        send_byte(8'd255);
        send_byte(8'd255);
        send_byte(8'd0);
        // Cut a frame short; the register write restarts it
        send_byte(8'd128);
        send_byte(8'd200);
        settle_idle();
        // Odd dimensions fold to 4x2; a spare code changes nothing
        write_register(CFG_FRAME_WIDTH, 11'd5);
        write_register(CFG_FRAME_HEIGHT, 11'd3);
        write_register(CFG_SPARE_2, 11'h7FF);
        send_byte(8'd15);
        send_byte(8'd16);
        send_byte(8'd235);
        send_byte(8'd128);
        send_byte(8'd1);
        send_byte(8'd254);
        send_byte(8'd100);
        send_byte(8'd50);
        send_byte(8'd128);
        send_byte(8'd128);
        send_byte(8'd1);
        send_byte(8'd254);

        // Random phases of small frames
        eff_w    = 4;
        eff_h    = 2;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle_idle();
            if (phase_no == 1)
            begin
                eff_w = 2;
                eff_h = 2;
            end
            else
            begin
                eff_w = random_dim();
            end
            write_register(CFG_FRAME_WIDTH, dim_register(eff_w));
            if (phase_no <= 1 || $urandom_range(0, 3) != 0)
            begin
                if (phase_no != 1)
                begin
                    eff_h = random_dim();
                end
                write_register(CFG_FRAME_HEIGHT, dim_register(eff_h));
            end
            if (phase_no == 0 || $urandom_range(0, 5) == 0)
            begin
                write_register(CFG_SPARE_3, 11'($urandom_range(0, 2047)));
            end
            frame_len = eff_w * eff_h * 3 / 2;
            if (phase_no == 1)
            begin
                n_bytes = frame_len * 8;
            end
            else
            begin
                n_bytes = frame_len * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                begin
                    n_bytes += $urandom_range(1, frame_len - 1);
                end
            end
            // Keep the first phase short and those after the second within the byte budget
            if (phase_no == 0 && n_bytes > FIRST_PHASE_BYTES)
            begin
                n_bytes = FIRST_PHASE_BYTES;
            end
            else if (phase_no > 1 && n_bytes > RANDOM_ITEMS - random_items)
            begin
                n_bytes = RANDOM_ITEMS - random_items;
            end
            bursty   = (phase_no != 1) && ($urandom_range(0, 9) < 7);
            pause_at = (phase_no == 0 || $urandom_range(0, 5) == 0) ?
                       $urandom_range(1, n_bytes - 1) : -1;
            // Hold the sink off while the sender keeps offering words
            if (phase_no == 1)
            begin
                holds_asked++;
            end
            for (i = 0; i < n_bytes; i++)
            begin
                if (i == pause_at)
                begin
                    lower_input();
                    while (pixels_left != 0)
                    begin
                        @(negedge clk);
                    end
                end
                send_byte(random_byte());
            end
            random_items += n_bytes;
            phase_no++;
        end

        lower_input();
        while (pixels_left != 0)
        begin
            @(negedge clk);
        end
        repeat (END_CYCLES) @(negedge clk);
        if (fail_count == 0 && pixels_left == 0)
        begin
            $display("nv21_to_rgb888_converter_tb: PASS");
        end
        else
        begin
            $display("nv21_to_rgb888_converter_tb: FAIL");
        end
        $finish;
    end

endmodule

/* nv21_to_rgb888_converter.f */
hw/rtl/n2r_pkg.sv
hw/rtl/n2r_stream_if.sv
hw/rtl/n2r_pixel_calc.sv
hw/rtl/nv21_to_rgb888_converter.sv
hw/rtl/n2r_checker.sv
test/nv21_pixel_checker.sv
test/nv21_to_rgb888_converter_tb.sv
